>>> rtl/segment_box_slab_test_top_assert.svh
// Assertion macros used by the checker file.
`ifndef SEGMENT_BOX_SLAB_TEST_TOP_ASSERT_SVH
`define SEGMENT_BOX_SLAB_TEST_TOP_ASSERT_SVH

// Property checked only outside reset.
`define SBST_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked in and out of reset.
`define SBST_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/sbst_pkg.sv
package sbst_pkg;

   // Per-item control handed to each slab divider.
   typedef struct packed {
      logic advance;
      logic neg;
   } div_ctl_type;

   // Per-axis flags that ride alongside the divider pipeline.
   typedef struct packed {
      logic zero;
      logic miss;
   } axis_flag_type;

endpackage

>>> rtl/segment_box_slab_test_top.sv
// Segment versus axis-aligned box, slab method, fully pipelined.
// Throughput: one request per cycle while the result register is not held;
// six dividers each retire one quotient bit per stage, so depth follows
// T_FRAC_BITS.
// Reset: synchronous, active high, clears all valid bits; data is not reset.
module segment_box_slab_test_top
   import sbst_pkg::*;
#(
   parameter int COORD_BITS  = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_start_z,
   input  logic signed [COORD_BITS-1:0] req_stop_x,
   input  logic signed [COORD_BITS-1:0] req_stop_y,
   input  logic signed [COORD_BITS-1:0] req_stop_z,
   input  logic signed [COORD_BITS-1:0] req_box_lo_x,
   input  logic signed [COORD_BITS-1:0] req_box_lo_y,
   input  logic signed [COORD_BITS-1:0] req_box_lo_z,
   input  logic signed [COORD_BITS-1:0] req_box_hi_x,
   input  logic signed [COORD_BITS-1:0] req_box_hi_y,
   input  logic signed [COORD_BITS-1:0] req_box_hi_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic [T_FRAC_BITS:0]         rsp_entry_t
);

   localparam int CW      = COORD_BITS;
   localparam int TW      = T_FRAC_BITS + 3;
   localparam int DIV_LAT = T_FRAC_BITS + 2;
   localparam logic signed [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

   logic en;

   // Advance the whole pipe unless the result register is held
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // Stage 1: capture the request
   logic signed [CW-1:0] start_ff [3];
   logic signed [CW-1:0] stop_ff  [3];
   logic signed [CW-1:0] lo_ff    [3];
   logic signed [CW-1:0] hi_ff    [3];
   logic                 v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         start_ff[0] <= req_start_x;
         start_ff[1] <= req_start_y;
         start_ff[2] <= req_start_z;
         stop_ff[0]  <= req_stop_x;
         stop_ff[1]  <= req_stop_y;
         stop_ff[2]  <= req_stop_z;
         lo_ff[0]    <= req_box_lo_x;
         lo_ff[1]    <= req_box_lo_y;
         lo_ff[2]    <= req_box_lo_z;
         hi_ff[0]    <= req_box_hi_x;
         hi_ff[1]    <= req_box_hi_y;
         hi_ff[2]    <= req_box_hi_z;
      end
   end

   // Stage 2: direction and slab numerators
   logic signed [CW:0] d_ff  [3];
   logic signed [CW:0] nl_ff [3];
   logic signed [CW:0] nh_ff [3];
   logic               v2_ff;

   // Stage 3: magnitudes, signs and zero-direction test
   logic [CW:0]   dmag_ff [3];
   logic [CW:0]   lmag_ff [3];
   logic [CW:0]   hmag_ff [3];
   logic          negl_ff [3];
   logic          negh_ff [3];
   axis_flag_type flag_ff [3];
   logic          v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   logic signed [TW-1:0] tq_lo [3];
   logic signed [TW-1:0] tq_hi [3];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [CW:0] d_in;
      logic signed [CW:0] nl_in;
      logic signed [CW:0] nh_in;
      logic [CW:0]        dmag_in;
      logic [CW:0]        lmag_in;
      logic [CW:0]        hmag_in;
      axis_flag_type      flag_in;
      div_ctl_type        ctl_lo;
      div_ctl_type        ctl_hi;

      always_comb begin
         d_in  = (CW+1)'(stop_ff[a]) - (CW+1)'(start_ff[a]);
         nl_in = (CW+1)'(lo_ff[a]) - (CW+1)'(start_ff[a]);
         nh_in = (CW+1)'(hi_ff[a]) - (CW+1)'(start_ff[a]);
      end

      always_comb begin
         dmag_in      = d_ff[a][CW]  ? -d_ff[a]  : d_ff[a];
         lmag_in      = nl_ff[a][CW] ? -nl_ff[a] : nl_ff[a];
         hmag_in      = nh_ff[a][CW] ? -nh_ff[a] : nh_ff[a];
         flag_in.zero = (d_ff[a] == '0);
         // Standing still outside the slab misses
         flag_in.miss = flag_in.zero && ((nl_ff[a] > 0) || nh_ff[a][CW]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[a]    <= d_in;
            nl_ff[a]   <= nl_in;
            nh_ff[a]   <= nh_in;
            dmag_ff[a] <= dmag_in;
            lmag_ff[a] <= lmag_in;
            hmag_ff[a] <= hmag_in;
            negl_ff[a] <= nl_ff[a][CW] ^ d_ff[a][CW];
            negh_ff[a] <= nh_ff[a][CW] ^ d_ff[a][CW];
            flag_ff[a] <= flag_in;
         end
      end

      assign ctl_lo = '{advance: en, neg: negl_ff[a]};
      assign ctl_hi = '{advance: en, neg: negh_ff[a]};

      sbst_slab_div #(
         .COORD_BITS  (COORD_BITS),
         .T_FRAC_BITS (T_FRAC_BITS)
      ) u_div_lo (
         .clock   (clock),
         .ctl     (ctl_lo),
         .num_mag (lmag_ff[a]),
         .den_mag (dmag_ff[a]),
         .quot    (tq_lo[a])
      );

      sbst_slab_div #(
         .COORD_BITS  (COORD_BITS),
         .T_FRAC_BITS (T_FRAC_BITS)
      ) u_div_hi (
         .clock   (clock),
         .ctl     (ctl_hi),
         .num_mag (hmag_ff[a]),
         .den_mag (dmag_ff[a]),
         .quot    (tq_hi[a])
      );
   end

   // Carry valid and axis flags alongside the dividers
   axis_flag_type side_ff [DIV_LAT][3];
   logic          vside_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            vside_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vside_ff[0] <= v3_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            vside_ff[i] <= vside_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            side_ff[0][a] <= flag_ff[a];
            for (int i = 1; i < DIV_LAT; i++) begin
               side_ff[i][a] <= side_ff[i-1][a];
            end
         end
      end
   end

   // Order each slab pair; a zero-direction axis leaves the interval alone
   logic signed [TW-1:0] tlo_ff  [3];
   logic signed [TW-1:0] thi_ff  [3];
   logic signed [TW-1:0] tlo_in  [3];
   logic signed [TW-1:0] thi_in  [3];
   logic [2:0]           amiss_ff;
   logic                 vord_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (side_ff[DIV_LAT-1][a].zero) begin
            tlo_in[a] = '0;
            thi_in[a] = T_ONE;
         end else if (tq_lo[a] > tq_hi[a]) begin
            tlo_in[a] = tq_hi[a];
            thi_in[a] = tq_lo[a];
         end else begin
            tlo_in[a] = tq_lo[a];
            thi_in[a] = tq_hi[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            tlo_ff[a]   <= tlo_in[a];
            thi_ff[a]   <= thi_in[a];
            amiss_ff[a] <= side_ff[DIV_LAT-1][a].miss;
         end
      end
   end

   // Narrow [0, 1.0] by all three axes
   logic signed [TW-1:0] mx_a;
   logic signed [TW-1:0] mx_b;
   logic signed [TW-1:0] mn_a;
   logic signed [TW-1:0] mn_b;
   logic signed [TW-1:0] tmin_ff;
   logic signed [TW-1:0] tmax_ff;
   logic                 miss_ff;
   logic                 vred_ff;

   always_comb begin
      mx_a = (tlo_ff[0] > 0) ? tlo_ff[0] : '0;
      mx_b = (tlo_ff[1] > tlo_ff[2]) ? tlo_ff[1] : tlo_ff[2];
      mn_a = (thi_ff[0] < T_ONE) ? thi_ff[0] : T_ONE;
      mn_b = (thi_ff[1] < thi_ff[2]) ? thi_ff[1] : thi_ff[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tmin_ff <= (mx_a > mx_b) ? mx_a : mx_b;
         tmax_ff <= (mn_a < mn_b) ? mn_a : mn_b;
         miss_ff <= |amiss_ff;
      end
   end

   // Hold the result until it is taken
   logic                 hit;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [T_FRAC_BITS:0] rsp_entry_ff;

   assign hit = !miss_ff && (tmin_ff <= tmax_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vord_ff      <= 1'b0;
         vred_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vord_ff      <= vside_ff[DIV_LAT-1];
         vred_ff      <= vord_ff;
         rsp_valid_ff <= vred_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff   <= hit;
         rsp_entry_ff <= hit ? tmin_ff[T_FRAC_BITS:0] : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_entry_t = rsp_entry_ff;

endmodule

>>> rtl/sbst_slab_div.sv
module sbst_slab_div
   import sbst_pkg::*;
#(
   parameter int COORD_BITS  = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  div_ctl_type                  ctl,
   input  logic [COORD_BITS:0]          num_mag,
   input  logic [COORD_BITS:0]          den_mag,
   output logic signed [T_FRAC_BITS+2:0] quot
);

   localparam int MW = COORD_BITS + 1;
   localparam int QW = T_FRAC_BITS + 1;
   localparam int TW = T_FRAC_BITS + 3;

   logic [MW-1:0] r_ff   [T_FRAC_BITS+1];
   logic [MW-1:0] den_ff [T_FRAC_BITS+1];
   logic [QW-1:0] q_ff   [T_FRAC_BITS+1];
   logic          sat_ff [T_FRAC_BITS+1];
   logic          neg_ff [T_FRAC_BITS+1];
   logic signed [TW-1:0] quot_ff;

   logic [MW:0]   den2;
   logic          sat_in;
   logic          q0_in;
   logic [MW-1:0] r0_in;

   // Check saturation and take the integer quotient bit
   always_comb begin
      den2   = {den_mag, 1'b0};
      sat_in = ({1'b0, num_mag} >= den2);
      q0_in  = (num_mag >= den_mag);
      r0_in  = q0_in ? (num_mag - den_mag) : num_mag;
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         r_ff[0]   <= r0_in;
         den_ff[0] <= den_mag;
         q_ff[0]   <= {{(QW-1){1'b0}}, q0_in};
         sat_ff[0] <= sat_in;
         neg_ff[0] <= ctl.neg;
      end
   end

   // One fraction bit per stage, restoring division
   for (genvar j = 1; j <= T_FRAC_BITS; j++) begin : g_step
      logic [MW:0]   r2;
      logic [MW:0]   diff;
      logic          ge;
      logic [MW-1:0] r_in;
      logic [QW-1:0] q_in;

      always_comb begin
         r2   = {r_ff[j-1], 1'b0};
         diff = r2 - {1'b0, den_ff[j-1]};
         ge   = (r2 >= {1'b0, den_ff[j-1]});
         r_in = ge ? diff[MW-1:0] : r2[MW-1:0];
         q_in = {q_ff[j-1][QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            r_ff[j]   <= r_in;
            den_ff[j] <= den_ff[j-1];
            q_ff[j]   <= q_in;
            sat_ff[j] <= sat_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   logic [TW-1:0]        mag;
   logic signed [TW-1:0] quot_in;

   // Saturate to 2.0 and apply the sign
   always_comb begin
      mag     = sat_ff[T_FRAC_BITS] ? (TW'(1) << (T_FRAC_BITS + 1))
                                    : {2'b00, q_ff[T_FRAC_BITS]};
      quot_in = neg_ff[T_FRAC_BITS] ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

>>> rtl/sbst_checker.sv
`include "segment_box_slab_test_top_assert.svh"

module sbst_checker #(
   parameter int T_FRAC_BITS = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_hit,
   input logic [T_FRAC_BITS:0] rsp_entry_t
);

   localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

   // Nothing comes out right after reset
   `SBST_ASSERT_ALWAYS(a_rst_quiet, reset |=> !rsp_valid, "result valid after reset")

   // A held result stays offered
   `SBST_ASSERT(a_hold, rsp_valid && rsp_stall |=> rsp_valid, "held result dropped")

   // Input backs up only while the result is held
   `SBST_ASSERT(a_stall_src, req_stall |-> (rsp_valid && rsp_stall), "needless request stall")

   // A miss reports zero, a hit stays within [0, 1.0]
   `SBST_ASSERT(a_miss_zero, rsp_valid && !rsp_hit |-> rsp_entry_t == '0, "miss with nonzero t")
   `SBST_ASSERT(a_t_range, rsp_valid && (req_valid || !req_valid) |-> rsp_entry_t <= T_ONE, "t above one")

endmodule

bind segment_box_slab_test_top sbst_checker #(
   .T_FRAC_BITS (T_FRAC_BITS)
) u_sbst_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_hit     (rsp_hit),
   .rsp_entry_t (rsp_entry_t)
);

>>> bench/tb_segment_box_slab_test_top.sv
module tb_segment_box_slab_test_top;
   import sbst_pkg::*;

   localparam int CB = 32;
   localparam int TF = 16;
   localparam int LATENCY = TF + 8;
   localparam int N_RANDOM = 1900;
   localparam int TAIL_START = 1700;
   localparam int CYCLE_LIMIT = 400000;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct {
      coord_type c[12];
   } segment_box_type;

   typedef struct {
      logic          hit;
      logic [TF:0]   entry_t;
   } slab_result_type;

   // Slab parameter: num * 2^TF / den, truncated toward zero, saturated to +-2.0.
   function automatic longint slab_param(longint num, longint den);
      logic      neg;
      longint    un, ud, q, r;
      neg = (num < 0) != (den < 0);
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      if (un >= 2 * ud) begin
         q = 2 * (longint'(1) << TF);
      end else begin
         q = (un >= ud) ? 1 : 0;
         r = un - q * ud;
         for (int i = 0; i < TF; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
               r = r - ud;
               q = q | 1;
            end
         end
      end
      return neg ? -q : q;
   endfunction

   function automatic slab_result_type predict_slab_hit(segment_box_type sb);
      slab_result_type res;
      longint tmin, tmax, s, e, lo, hi, d, t1, t2, tt;
      logic   hit;
      tmin = 0;
      tmax = longint'(1) << TF;
      hit = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if (hit) begin
            s = sb.c[a];
            e = sb.c[3+a];
            lo = sb.c[6+a];
            hi = sb.c[9+a];
            d = e - s;
            if (d == 0) begin
               if (s < lo || s > hi) hit = 1'b0;
            end else begin
               t1 = slab_param(lo - s, d);
               t2 = slab_param(hi - s, d);
               if (t1 > t2) begin
                  tt = t1; t1 = t2; t2 = tt;
               end
               if (t1 > tmin) tmin = t1;
               if (t2 < tmax) tmax = t2;
               if (tmin > tmax) hit = 1'b0;
            end
         end
      end
      res.hit = hit;
      res.entry_t = hit ? tmin[TF:0] : '0;
      return res;
   endfunction

   class slab_scoreboard;
      slab_result_type pending[$];
      int              mismatches;

      function void note_request(segment_box_type sb);
         pending.push_back(predict_slab_hit(sb));
      endfunction

      function void check_result(logic hit, logic [TF:0] entry_t);
         slab_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result hit=%0d t=%0d", hit, entry_t);
            return;
         end
         want = pending.pop_front();
         if (want.hit !== hit || want.entry_t !== entry_t) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected hit=%0d t=%0d, got hit=%0d t=%0d",
                        want.hit, want.entry_t, hit, entry_t);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, rsp_hit;
   logic [TF:0] rsp_entry_t;
   coord_type req_c[12];

   slab_scoreboard board;
   int  cycles;
   logic tail_phase;

   segment_box_slab_test_top #(.COORD_BITS(CB), .T_FRAC_BITS(TF)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_x(req_c[0]), .req_start_y(req_c[1]), .req_start_z(req_c[2]),
      .req_stop_x(req_c[3]), .req_stop_y(req_c[4]), .req_stop_z(req_c[5]),
      .req_box_lo_x(req_c[6]), .req_box_lo_y(req_c[7]), .req_box_lo_z(req_c[8]),
      .req_box_hi_x(req_c[9]), .req_box_hi_y(req_c[10]), .req_box_hi_z(req_c[11]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit), .rsp_entry_t(rsp_entry_t)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort on a runaway run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Note accepted requests and check accepted results.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_request('{c: req_c});
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_hit, rsp_entry_t);
   end

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
         2: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return coord_type'($signed($urandom_range(0, 32'h0000_2000)) - 32'sh1000);
      endcase
   endfunction

   // Mostly segments aimed through a sensible box, with noise mixed in.
   function automatic segment_box_type rand_request();
      segment_box_type sb;
      int mode;
      coord_type a, b;
      mode = $urandom_range(0, 9);
      for (int ax = 0; ax < 3; ax++) begin
         if (mode == 0) begin
            for (int k = 0; k < 4; k++) sb.c[ax + 3*k] = rand_coord($urandom_range(0, 3));
         end else begin
            a = rand_coord(1);
            b = rand_coord(1);
            sb.c[6+ax] = (a < b) ? a : b;
            sb.c[9+ax] = (a < b) ? b : a;
            if (mode == 1) sb.c[9+ax] = a;
            sb.c[ax] = rand_coord(1) * 2;
            sb.c[3+ax] = ($urandom_range(0, 7) == 0) ? sb.c[ax] : rand_coord(1) * 2;
            if (mode == 2) sb.c[3+ax] = sb.c[ax] + coord_type'($urandom_range(0, 4)) - 2;
         end
      end
      return sb;
   endfunction

   task automatic send_request(segment_box_type sb, logic allow_gap);
      int gap;
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_c <= sb.c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic segment_box_type make_box(coord_type s0, coord_type s1, coord_type s2,
                                                coord_type e0, coord_type e1, coord_type e2,
                                                coord_type lo, coord_type hi);
      segment_box_type sb;
      sb.c = '{s0, s1, s2, e0, e1, e2, lo, lo, lo, hi, hi, hi};
      return sb;
   endfunction

   // Drive directed cases, then random requests.
   task automatic drive_requests();
      segment_box_type sb;
      coord_type one;
      one = 32'sh0001_0000;
      send_request(make_box(-2*one, 0, 0, 2*one, 0, 0, -one, one), 1'b0);
      send_request(make_box(0, 0, 0, 0, 0, 0, -one, one), 1'b0);
      send_request(make_box(2*one, 0, 0, 2*one, 0, 0, -one, one), 1'b0);
      send_request(make_box(-2*one, one, 0, 2*one, one, 0, -one, one), 1'b0);
      send_request(make_box(-2*one, -2*one, -2*one, 2*one, 2*one, 2*one, -one, one), 1'b0);
      send_request(make_box(5*one, 5*one, 5*one, 6*one, 6*one, 6*one, -one, one), 1'b0);
      send_request(make_box(-one, -one, -one, one, one, one, one, -one), 1'b0);
      send_request(make_box(0, 0, 0, 0, 0, 0, one, -one), 1'b0);
      send_request(make_box(-one, -one, -one, one, -one, -one, -one, one), 1'b0);
      send_request(make_box(32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, 0,
                            32'sh8000_0000, 32'sh7fff_ffff), 1'b0);
      send_request(make_box(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, -1, 1), 1'b0);
      send_request(make_box(0, 0, 0, 1, 1, 1, 32'sh8000_0000, 32'sh7fff_ffff), 1'b0);
      send_request(make_box(-1, 0, 0, 32'sh7fff_ffff, 0, 0, 0, 0), 1'b0);
      send_request(make_box(one, one, one, -one, -one, -one, 0, 0), 1'b0);
      send_request(make_box(32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff,
                            32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff,
                            32'shffff_ffff, 32'shffff_ffff), 1'b0);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == TAIL_START) tail_phase = 1'b1;
         sb = rand_request();
         send_request(sb, !tail_phase);
      end
      req_valid <= 1'b0;
   endtask

   // Stall the result channel in bursts, with one long hold-off early on.
   initial begin
      int burst;
      rsp_stall = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_stall <= 1'b1;
      repeat (200) @(posedge clock);
      forever begin
         if (!tail_phase && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   initial begin
      board = new();
      cycles = 0;
      tail_phase = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      for (int k = 0; k < 12; k++) req_c[k] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      drive_requests();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY * 2) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
